// File: hdl/netlist_token_lexer_defines.svh
// Assertion macros for the netlist token lexer.
// Used by the top level; expects clk and rst_n in scope.
`ifndef NETLIST_TOKEN_LEXER_DEFINES_SVH
`define NETLIST_TOKEN_LEXER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define NTL_CHECK_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define NTL_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ntl_pkg.sv
// Shared types, constants and character-class functions for the netlist lexer.
// No dependencies.
package ntl_pkg;

    localparam int TEXT_W     = 8;
    localparam int KIND_W     = 5;
    localparam int OUT_COL_W  = 16;
    localparam int OUT_LINE_W = 24;
    localparam int OUT_LEN_W  = 9;
    localparam int NUM_KW     = 7;
    localparam int KW_MAX_LEN = 9;
    localparam int MAX_RECS   = 3;

    typedef logic [TEXT_W-1:0]     char_t;
    typedef logic [KIND_W-1:0]     kind_t;
    typedef logic [OUT_COL_W-1:0]  col_out_t;
    typedef logic [OUT_LINE_W-1:0] line_out_t;
    typedef logic [OUT_LEN_W-1:0]  len_out_t;
    typedef logic [NUM_KW-1:0]     kw_mask_t;
    typedef logic [1:0]            rec_cnt_t;

    localparam kind_t KIND_IDENT = 5'd0;
    localparam kind_t KIND_EQ    = 5'd8;
    localparam kind_t KIND_LPAR  = 5'd9;
    localparam kind_t KIND_RPAR  = 5'd10;
    localparam kind_t KIND_LBRC  = 5'd11;
    localparam kind_t KIND_RBRC  = 5'd12;
    localparam kind_t KIND_LBKT  = 5'd13;
    localparam kind_t KIND_RBKT  = 5'd14;
    localparam kind_t KIND_COMMA = 5'd15;
    localparam kind_t KIND_SEMI  = 5'd16;
    localparam kind_t KIND_COLON = 5'd17;
    localparam kind_t KIND_DOT   = 5'd18;
    localparam kind_t KIND_BASED = 5'd19;
    localparam kind_t KIND_UINT  = 5'd20;
    localparam kind_t KIND_EOF   = 5'd21;
    localparam kind_t KIND_ERR   = 5'd22;

    localparam char_t CH_LF     = 8'h0A;
    localparam char_t CH_SLASH  = 8'h2F;
    localparam char_t CH_STAR   = 8'h2A;
    localparam char_t CH_BSLASH = 8'h5C;
    localparam char_t CH_QUOTE  = 8'h27;
    localparam char_t CH_UNDER  = 8'h5F;

    localparam kw_mask_t KW_ALL = '1;

    typedef enum logic [9:0] {
        MODE_IDLE    = 10'b00_0000_0001,
        MODE_SLASH   = 10'b00_0000_0010,
        MODE_LINECMT = 10'b00_0000_0100,
        MODE_BLOCK   = 10'b00_0000_1000,
        MODE_STAR    = 10'b00_0001_0000,
        MODE_IDENT   = 10'b00_0010_0000,
        MODE_ESC     = 10'b00_0100_0000,
        MODE_UINT    = 10'b00_1000_0000,
        MODE_BASE    = 10'b01_0000_0000,
        MODE_DIGITS  = 10'b10_0000_0000
    } lex_mode_t;

    typedef struct packed {
        char_t     text_byte;
        logic      token_end;
        kind_t     kind;
        col_out_t  start_column;
        line_out_t line_number;
        len_out_t  text_length;
    } rec_t;

    typedef struct packed {
        logic     ended;
        rec_cnt_t rec_count;
    } core_status_t;

    typedef struct packed {
        logic     can_load;
        rec_cnt_t count;
    } outq_status_t;

    typedef logic [0:KW_MAX_LEN-1][7:0] kw_str_t;

    localparam kw_str_t KW_TEXT [NUM_KW] = '{
        "module   ", "endmodule", "input    ", "output   ",
        "inout    ", "wire     ", "assign   "
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd6, 4'd9, 4'd5, 4'd6, 4'd5, 4'd4, 4'd6
    };

    function automatic logic is_space(char_t c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(char_t c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(char_t c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_hex_lc(char_t c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic is_base(char_t c);
        return c == 8'h62 || c == 8'h64 || c == 8'h6F || c == 8'h68;
    endfunction

    function automatic char_t to_lower(char_t c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
    endfunction

    function automatic kind_t punct_kind(char_t c);
        kind_t k;
        case (c)
            8'h3D:   k = KIND_EQ;
            8'h28:   k = KIND_LPAR;
            8'h29:   k = KIND_RPAR;
            8'h7B:   k = KIND_LBRC;
            8'h7D:   k = KIND_RBRC;
            8'h5B:   k = KIND_LBKT;
            8'h5D:   k = KIND_RBKT;
            8'h2C:   k = KIND_COMMA;
            8'h3B:   k = KIND_SEMI;
            8'h3A:   k = KIND_COLON;
            8'h2E:   k = KIND_DOT;
            default: k = KIND_IDENT;
        endcase
        return k;
    endfunction

    // pos must be below KW_MAX_LEN
    function automatic kw_mask_t kw_update(kw_mask_t cand, logic [3:0] pos, char_t c);
        kw_mask_t m;
        m = cand;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (pos >= KW_LEN[k] || KW_TEXT[k][pos] != c)
                m[k] = 1'b0;
        end
        return m;
    endfunction

    // first surviving keyword whose length matches wins
    function automatic kind_t ident_kind(kw_mask_t cand, logic [3:0] len, logic len_ok);
        kind_t k_out;
        k_out = KIND_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--)
        begin
            if (cand[k] && len_ok && KW_LEN[k] == len)
                k_out = kind_t'(k + 1);
        end
        return k_out;
    endfunction

endpackage

// File: hdl/ntl_in_if.sv
// Character input channel: one source byte or end-of-input mark per word.
// Depends on ntl_pkg.
interface ntl_in_if;
    logic           valid;
    logic           ready;
    ntl_pkg::char_t in_byte;
    logic           end_of_input;

    modport source (output valid, in_byte, end_of_input, input ready);
    modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

// File: hdl/ntl_out_if.sv
// Token record output channel: one text or closing record per word.
// Depends on ntl_pkg.
interface ntl_out_if;
    logic                 valid;
    logic                ready;
    ntl_pkg::char_t      text_byte;
    logic                token_end;
    ntl_pkg::kind_t      kind;
    ntl_pkg::col_out_t   start_column;
    ntl_pkg::line_out_t  line_number;
    ntl_pkg::len_out_t   text_length;

    modport source (output valid, text_byte, token_end, kind, start_column,
                    line_number, text_length, input ready);
    modport sink   (input valid, text_byte, token_end, kind, start_column,
                    line_number, text_length, output ready);
endinterface

// File: hdl/netlist_token_lexer.sv
// A byte is registered at acceptance; its records enter the result register once it can load.
// Throughput: one byte per cycle while each byte yields at most one record and the output is
// ready; a byte that yields more (up to 3) holds the input until the one-word output drains them.
// Reset (rst_n low, async): idle mode, line 1, column 0, no input or output word held.
// Depends on ntl_pkg, ntl_in_if, ntl_out_if, ntl_core, ntl_outq and the defines header.
`include "netlist_token_lexer_defines.svh"

module netlist_token_lexer #(
    parameter int MAX_TOKEN_LEN = 256,
    parameter int LINE_BITS     = 24,
    parameter int COLUMN_BITS   = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ntl_in_if.sink    chars,
    ntl_out_if.source tokens
);

    logic                  in_valid_reg;
    ntl_pkg::char_t        in_byte_reg;
    logic                  eoi_reg;
    logic                  advance;
    ntl_pkg::rec_t         recs [ntl_pkg::MAX_RECS];
    ntl_pkg::core_status_t core_st;
    ntl_pkg::outq_status_t outq_st;

    assign advance     = in_valid_reg && outq_st.can_load;
    assign chars.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (chars.valid && chars.ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            in_byte_reg <= chars.in_byte;
            eoi_reg     <= chars.end_of_input;
        end
    end

    ntl_core #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .LINE_BITS     (LINE_BITS),
        .COLUMN_BITS   (COLUMN_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_byte      (in_byte_reg),
        .end_of_input (eoi_reg),
        .recs         (recs),
        .status       (core_st)
    );

    ntl_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .load_count (core_st.rec_count),
        .load_recs  (recs),
        .tokens     (tokens),
        .status     (outq_st)
    );

    `NTL_CHECK_NEXT(a_recs_shown, advance && core_st.rec_count != 2'd0, tokens.valid, "records lost")
    `NTL_CHECK_NOW(a_eof_single, advance && core_st.ended, core_st.rec_count == 2'd1, "bad eof")
    `NTL_CHECK_NEXT(a_word_held, in_valid_reg && !advance, in_valid_reg && $stable(in_byte_reg), "word lost")
    `NTL_CHECK_NOW(a_no_overrun, advance, outq_st.count <= 2'd1, "result overwrite")

endmodule

// File: hdl/ntl_core.sv
// Lexer state registers and the per-byte next-state / record logic.
// Depends on ntl_pkg.
module ntl_core #(
    parameter int MAX_TOKEN_LEN = 256,
    parameter int LINE_BITS     = 24,
    parameter int COLUMN_BITS   = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  ntl_pkg::char_t        in_byte,
    input  logic                  end_of_input,
    output ntl_pkg::rec_t         recs [ntl_pkg::MAX_RECS],
    output ntl_pkg::core_status_t status
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

    ntl_pkg::lex_mode_t        mode_reg, mode_next;
    logic [LINE_BITS-1:0]      line_reg, line_next;
    logic [COLUMN_BITS-1:0]    col_reg, col_next;
    logic [COLUMN_BITS-1:0]    tok_col_reg, tok_col_next;
    logic [LEN_W-1:0]          tok_len_reg, tok_len_next;
    ntl_pkg::kw_mask_t         cand_reg, cand_next;
    logic                      ended_reg, ended_next;
    ntl_pkg::rec_cnt_t         rec_cnt;

    function automatic ntl_pkg::rec_t make_rec(
        ntl_pkg::char_t text, logic is_end, ntl_pkg::kind_t kind,
        logic [COLUMN_BITS-1:0] col, logic [LINE_BITS-1:0] line, logic [LEN_W-1:0] len);
        ntl_pkg::rec_t r;
        r.text_byte    = text;
        r.token_end    = is_end;
        r.kind         = kind;
        r.start_column = ntl_pkg::col_out_t'(col);
        r.line_number  = ntl_pkg::line_out_t'(line);
        r.text_length  = ntl_pkg::len_out_t'(len);
        return r;
    endfunction

    function automatic ntl_pkg::rec_t text_rec(ntl_pkg::char_t text);
        ntl_pkg::rec_t r;
        r = '0;
        r.text_byte = text;
        return r;
    endfunction

    always_comb
    begin
        ntl_pkg::char_t c;
        ntl_pkg::char_t l;
        logic           keep_a;
        ntl_pkg::char_t kc_a;
        logic           close_a;
        ntl_pkg::kind_t kind_a;
        logic           to_idle;
        logic           len_ok;

        c       = in_byte;
        l       = ntl_pkg::to_lower(in_byte);
        keep_a  = 1'b0;
        kc_a    = c;
        close_a = 1'b0;
        kind_a  = ntl_pkg::KIND_ERR;
        to_idle = 1'b0;
        len_ok  = tok_len_reg <= LEN_W'(ntl_pkg::KW_MAX_LEN);

        mode_next    = mode_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        tok_col_next = tok_col_reg;
        tok_len_next = tok_len_reg;
        cand_next    = cand_reg;
        ended_next   = ended_reg;
        rec_cnt      = '0;
        for (int i = 0; i < ntl_pkg::MAX_RECS; i++)
            recs[i] = '0;

        if (ended_reg)
        begin
            recs[rec_cnt] = make_rec('0, 1'b1, ntl_pkg::KIND_EOF, col_reg, line_reg, '0);
            rec_cnt = rec_cnt + 2'd1;
        end
        else if (end_of_input)
        begin
            case (mode_reg)
                ntl_pkg::MODE_IDENT:
                begin
                    close_a = 1'b1;
                    kind_a  = ntl_pkg::ident_kind(cand_reg, tok_len_reg[3:0], len_ok);
                end
                ntl_pkg::MODE_ESC:
                begin
                    close_a = 1'b1;
                    kind_a  = ntl_pkg::KIND_IDENT;
                end
                ntl_pkg::MODE_IDLE, ntl_pkg::MODE_LINECMT: ;
                default: close_a = 1'b1;
            endcase
            if (close_a)
            begin
                recs[rec_cnt] = make_rec('0, 1'b1, kind_a, tok_col_reg, line_reg, tok_len_reg);
                rec_cnt = rec_cnt + 2'd1;
            end
            recs[rec_cnt] = make_rec('0, 1'b1, ntl_pkg::KIND_EOF, col_reg, line_reg, '0);
            rec_cnt = rec_cnt + 2'd1;
            mode_next    = ntl_pkg::MODE_IDLE;
            tok_len_next = '0;
            ended_next   = 1'b1;
        end
        else
        begin
            if (col_reg != COL_MAX)
                col_next = col_reg + COLUMN_BITS'(1);

            case (mode_reg)
                ntl_pkg::MODE_SLASH:
                begin
                    if (c == ntl_pkg::CH_SLASH)
                        mode_next = ntl_pkg::MODE_LINECMT;
                    else if (c == ntl_pkg::CH_STAR)
                        mode_next = ntl_pkg::MODE_BLOCK;
                    else
                        close_a = 1'b1;
                end
                ntl_pkg::MODE_LINECMT:
                begin
                    if (c == ntl_pkg::CH_LF)
                        mode_next = ntl_pkg::MODE_IDLE;
                end
                ntl_pkg::MODE_BLOCK:
                begin
                    if (c == ntl_pkg::CH_STAR)
                        mode_next = ntl_pkg::MODE_STAR;
                end
                ntl_pkg::MODE_STAR:
                begin
                    if (c == ntl_pkg::CH_SLASH)
                        mode_next = ntl_pkg::MODE_IDLE;
                    else if (c != ntl_pkg::CH_STAR)
                        mode_next = ntl_pkg::MODE_BLOCK;
                end
                ntl_pkg::MODE_IDENT:
                begin
                    if (ntl_pkg::is_alpha(c) || ntl_pkg::is_digit(c) || c == ntl_pkg::CH_UNDER)
                        keep_a = 1'b1;
                    else
                    begin
                        close_a = 1'b1;
                        kind_a  = ntl_pkg::ident_kind(cand_reg, tok_len_reg[3:0], len_ok);
                        to_idle = 1'b1;
                    end
                end
                ntl_pkg::MODE_ESC:
                begin
                    if (!ntl_pkg::is_space(c))
                        keep_a = 1'b1;
                    else
                    begin
                        close_a = 1'b1;
                        kind_a  = ntl_pkg::KIND_IDENT;
                        to_idle = 1'b1;
                    end
                end
                ntl_pkg::MODE_UINT:
                begin
                    if (ntl_pkg::is_digit(c))
                        keep_a = 1'b1;
                    else if (c != ntl_pkg::CH_UNDER)
                    begin
                        close_a = 1'b1;
                        kind_a  = ntl_pkg::KIND_UINT;
                        to_idle = 1'b1;
                    end
                end
                ntl_pkg::MODE_BASE:
                begin
                    if (ntl_pkg::is_base(l))
                    begin
                        keep_a    = 1'b1;
                        kc_a      = l;
                        mode_next = ntl_pkg::MODE_DIGITS;
                    end
                    else
                        close_a = 1'b1;
                end
                ntl_pkg::MODE_DIGITS:
                begin
                    if (ntl_pkg::is_hex_lc(l))
                    begin
                        keep_a = 1'b1;
                        kc_a   = l;
                    end
                    else if (c != ntl_pkg::CH_UNDER)
                    begin
                        close_a = 1'b1;
                        kind_a  = ntl_pkg::KIND_BASED;
                        to_idle = 1'b1;
                    end
                end
                default: to_idle = 1'b1;
            endcase

            // continue current token
            if (keep_a)
            begin
                if (tok_len_reg >= LEN_W'(MAX_TOKEN_LEN))
                    cand_next = '0;
                else
                begin
                    if (tok_len_reg > LEN_W'(ntl_pkg::KW_MAX_LEN - 1))
                        cand_next = '0;
                    else
                        cand_next = ntl_pkg::kw_update(cand_reg, tok_len_reg[3:0], kc_a);
                    recs[rec_cnt] = text_rec(kc_a);
                    rec_cnt = rec_cnt + 2'd1;
                    tok_len_next = tok_len_reg + LEN_W'(1);
                end
            end

            if (close_a)
            begin
                recs[rec_cnt] = make_rec('0, 1'b1, kind_a, tok_col_reg, line_reg, tok_len_reg);
                rec_cnt = rec_cnt + 2'd1;
                tok_len_next = '0;
                mode_next    = ntl_pkg::MODE_IDLE;
            end

            // byte lexed from idle
            if (to_idle)
            begin
                mode_next    = ntl_pkg::MODE_IDLE;
                tok_len_next = '0;
                cand_next    = ntl_pkg::KW_ALL;
                if (!ntl_pkg::is_space(c))
                begin
                    tok_col_next = col_next;
                    if (ntl_pkg::is_alpha(c) || c == ntl_pkg::CH_UNDER || ntl_pkg::is_digit(c)
                        || c == ntl_pkg::CH_QUOTE || ntl_pkg::punct_kind(c) != ntl_pkg::KIND_IDENT)
                    begin
                        cand_next = ntl_pkg::kw_update(ntl_pkg::KW_ALL, 4'd0, c);
                        recs[rec_cnt] = text_rec(c);
                        rec_cnt = rec_cnt + 2'd1;
                        tok_len_next = LEN_W'(1);
                    end
                    if (ntl_pkg::is_alpha(c) || c == ntl_pkg::CH_UNDER)
                        mode_next = ntl_pkg::MODE_IDENT;
                    else if (c == ntl_pkg::CH_BSLASH)
                        mode_next = ntl_pkg::MODE_ESC;
                    else if (ntl_pkg::is_digit(c))
                        mode_next = ntl_pkg::MODE_UINT;
                    else if (c == ntl_pkg::CH_QUOTE)
                        mode_next = ntl_pkg::MODE_BASE;
                    else if (c == ntl_pkg::CH_SLASH)
                        mode_next = ntl_pkg::MODE_SLASH;
                    else
                    begin
                        // punctuator, or stray byte with length 0
                        recs[rec_cnt] = make_rec('0, 1'b1,
                            (ntl_pkg::punct_kind(c) != ntl_pkg::KIND_IDENT)
                                ? ntl_pkg::punct_kind(c) : ntl_pkg::KIND_ERR,
                            col_next, line_reg, tok_len_next);
                        rec_cnt = rec_cnt + 2'd1;
                        tok_len_next = '0;
                    end
                end
            end

            if (c == ntl_pkg::CH_LF)
            begin
                if (line_reg != LINE_MAX)
                    line_next = line_reg + LINE_BITS'(1);
                col_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= ntl_pkg::MODE_IDLE;
            line_reg    <= LINE_BITS'(1);
            col_reg     <= '0;
            tok_col_reg <= '0;
            tok_len_reg <= '0;
            cand_reg    <= ntl_pkg::KW_ALL;
            ended_reg   <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            tok_col_reg <= tok_col_next;
            tok_len_reg <= tok_len_next;
            cand_reg    <= cand_next;
            ended_reg   <= ended_next;
        end
    end

    assign status.ended     = ended_reg;
    assign status.rec_count = rec_cnt;

endmodule

// File: hdl/ntl_outq.sv
// Result register: holds up to three records of one byte, drains one per cycle while the sink is ready.
// Depends on ntl_pkg and ntl_out_if.
module ntl_outq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  ntl_pkg::rec_cnt_t     load_count,
    input  ntl_pkg::rec_t         load_recs [ntl_pkg::MAX_RECS],
    ntl_out_if.source             tokens,
    output ntl_pkg::outq_status_t status
);

    ntl_pkg::rec_t     rec_reg [ntl_pkg::MAX_RECS];
    ntl_pkg::rec_cnt_t cnt_reg;
    logic              pop;

    assign pop             = (cnt_reg != 2'd0) && tokens.ready;
    assign status.can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && tokens.ready);
    assign status.count    = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (load)
            cnt_reg <= load_count;
        else if (pop)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rec_reg <= load_recs;
        else if (pop)
        begin
            for (int i = 0; i < ntl_pkg::MAX_RECS - 1; i++)
                rec_reg[i] <= rec_reg[i + 1];
        end
    end

    assign tokens.valid        = cnt_reg != 2'd0;
    assign tokens.text_byte    = rec_reg[0].text_byte;
    assign tokens.token_end    = rec_reg[0].token_end;
    assign tokens.kind         = rec_reg[0].kind;
    assign tokens.start_column = rec_reg[0].start_column;
    assign tokens.line_number  = rec_reg[0].line_number;
    assign tokens.text_length  = rec_reg[0].text_length;

endmodule

// File: tb/netlist_token_lexer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for netlist_token_lexer: streams source bytes with random gaps,
// predicts every token record and checks each one as it leaves the block.
// Depends on ntl_pkg, ntl_in_if, ntl_out_if and the lexer RTL.
module netlist_token_lexer_tb;

    localparam int TOKEN_CAP    = 256;
    localparam int RANDOM_WORDS = 180;
    localparam int LIMIT        = 1_000_000;
    localparam int SHOW_MAX     = 10;

    typedef struct {
        ntl_pkg::char_t ch;
        logic           eoi;
        int             gap;
        bit             drain;
    } src_word_t;

    logic clk;
    logic rst_n;

    ntl_in_if  chars_if();
    ntl_out_if tokens_if();

    netlist_token_lexer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .tokens (tokens_if)
    );

    string kw_word [ntl_pkg::NUM_KW] = '{"module", "endmodule", "input", "output", "inout",
                                         "wire", "assign"};
    string punct_chars = "=(){}[],;:.";

    // lexer prediction state
    ntl_pkg::lex_mode_t mode;
    ntl_pkg::line_out_t line_no;
    ntl_pkg::col_out_t  col_no;
    ntl_pkg::col_out_t  tok_col;
    int                 tok_len;
    ntl_pkg::kw_mask_t  cand;
    bit                 eof_seen;
    ntl_pkg::rec_t      pending_recs[$];

    src_word_t     src_words[$];
    bit            src_quiet;
    bit            sink_quiet;
    bit            drain_next;
    int            words_built;
    int            words_sent;
    int            recs_seen;
    int            fails;
    int            cycles;
    int            wait_cnt;
    int            stall_left;
    int            post_end_words;
    string         end_note;
    src_word_t     nxt;
    ntl_pkg::rec_t got;
    ntl_pkg::rec_t want;
    string         diffs;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pause_len(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    function automatic bit blank(ntl_pkg::char_t c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit numeral(ntl_pkg::char_t c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter(ntl_pkg::char_t c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic ntl_pkg::char_t fold_case(ntl_pkg::char_t c);
        return (c >= "A" && c <= "Z") ? ntl_pkg::char_t'(c + 8'd32) : c;
    endfunction

    function automatic ntl_pkg::kind_t punct_of(ntl_pkg::char_t c);
        case (c)
            "=":     return ntl_pkg::KIND_EQ;
            "(":     return ntl_pkg::KIND_LPAR;
            ")":     return ntl_pkg::KIND_RPAR;
            "{":     return ntl_pkg::KIND_LBRC;
            "}":     return ntl_pkg::KIND_RBRC;
            "[":     return ntl_pkg::KIND_LBKT;
            "]":     return ntl_pkg::KIND_RBKT;
            ",":     return ntl_pkg::KIND_COMMA;
            ";":     return ntl_pkg::KIND_SEMI;
            ":":     return ntl_pkg::KIND_COLON;
            ".":     return ntl_pkg::KIND_DOT;
            default: return ntl_pkg::KIND_IDENT;
        endcase
    endfunction

    function automatic void push_rec(ntl_pkg::char_t t, logic e, ntl_pkg::kind_t k,
                                     ntl_pkg::col_out_t c, ntl_pkg::line_out_t l,
                                     ntl_pkg::len_out_t n);
        ntl_pkg::rec_t r;
        r.text_byte    = t;
        r.token_end    = e;
        r.kind         = k;
        r.start_column = c;
        r.line_number  = l;
        r.text_length  = n;
        pending_recs.push_back(r);
    endfunction

    function automatic void keep_char(ntl_pkg::char_t c);
        if (tok_len >= TOKEN_CAP)
        begin
            cand = '0;
            return;
        end
        for (int k = 0; k < ntl_pkg::NUM_KW; k++)
        begin
            if (tok_len >= kw_word[k].len() || kw_word[k][tok_len] != c)
                cand[k] = 1'b0;
        end
        push_rec(c, 1'b0, ntl_pkg::KIND_IDENT, '0, '0, '0);
        tok_len++;
    endfunction

    function automatic void close_tok(ntl_pkg::kind_t k);
        push_rec('0, 1'b1, k, tok_col, line_no, ntl_pkg::len_out_t'(tok_len));
        tok_len = 0;
        mode = ntl_pkg::MODE_IDLE;
    endfunction

    function automatic ntl_pkg::kind_t word_kind();
        for (int k = 0; k < ntl_pkg::NUM_KW; k++)
        begin
            if (cand[k] && kw_word[k].len() == tok_len)
                return ntl_pkg::kind_t'(k + 1);
        end
        return ntl_pkg::KIND_IDENT;
    endfunction

    function automatic void start_fresh(ntl_pkg::char_t c);
        ntl_pkg::kind_t pk;
        mode = ntl_pkg::MODE_IDLE;
        tok_len = 0;
        cand = ntl_pkg::KW_ALL;
        if (blank(c))
            return;
        tok_col = col_no;
        pk = punct_of(c);
        if (letter(c) || c == ntl_pkg::CH_UNDER)
        begin
            mode = ntl_pkg::MODE_IDENT;
            keep_char(c);
        end
        else if (c == ntl_pkg::CH_BSLASH)
            mode = ntl_pkg::MODE_ESC;
        else if (numeral(c))
        begin
            mode = ntl_pkg::MODE_UINT;
            keep_char(c);
        end
        else if (c == ntl_pkg::CH_QUOTE)
        begin
            mode = ntl_pkg::MODE_BASE;
            keep_char(c);
        end
        else if (c == ntl_pkg::CH_SLASH)
            mode = ntl_pkg::MODE_SLASH;
        else if (pk != ntl_pkg::KIND_IDENT)
        begin
            keep_char(c);
            close_tok(pk);
        end
        else
            close_tok(ntl_pkg::KIND_ERR);
    endfunction

    // records caused by one accepted source word
    function automatic void lex_char(ntl_pkg::char_t c, logic eoi);
        ntl_pkg::char_t lc;
        if (eof_seen)
        begin
            push_rec('0, 1'b1, ntl_pkg::KIND_EOF, col_no, line_no, '0);
            return;
        end
        if (eoi)
        begin
            case (mode)
                ntl_pkg::MODE_IDENT:                       close_tok(word_kind());
                ntl_pkg::MODE_ESC:                         close_tok(ntl_pkg::KIND_IDENT);
                ntl_pkg::MODE_IDLE, ntl_pkg::MODE_LINECMT: ;
                default:                                   close_tok(ntl_pkg::KIND_ERR);
            endcase
            push_rec('0, 1'b1, ntl_pkg::KIND_EOF, col_no, line_no, '0);
            mode = ntl_pkg::MODE_IDLE;
            tok_len = 0;
            eof_seen = 1'b1;
            return;
        end
        if (col_no != '1)
            col_no++;
        lc = fold_case(c);
        case (mode)
            ntl_pkg::MODE_SLASH:
                if (c == ntl_pkg::CH_SLASH)
                    mode = ntl_pkg::MODE_LINECMT;
                else if (c == ntl_pkg::CH_STAR)
                    mode = ntl_pkg::MODE_BLOCK;
                else
                    close_tok(ntl_pkg::KIND_ERR);
            ntl_pkg::MODE_LINECMT:
                if (c == ntl_pkg::CH_LF)
                    mode = ntl_pkg::MODE_IDLE;
            ntl_pkg::MODE_BLOCK:
                if (c == ntl_pkg::CH_STAR)
                    mode = ntl_pkg::MODE_STAR;
            ntl_pkg::MODE_STAR:
                if (c == ntl_pkg::CH_SLASH)
                    mode = ntl_pkg::MODE_IDLE;
                else if (c != ntl_pkg::CH_STAR)
                    mode = ntl_pkg::MODE_BLOCK;
            ntl_pkg::MODE_IDENT:
                if (letter(c) || numeral(c) || c == ntl_pkg::CH_UNDER)
                    keep_char(c);
                else
                begin
                    close_tok(word_kind());
                    start_fresh(c);
                end
            ntl_pkg::MODE_ESC:
                if (!blank(c))
                    keep_char(c);
                else
                begin
                    close_tok(ntl_pkg::KIND_IDENT);
                    start_fresh(c);
                end
            ntl_pkg::MODE_UINT:
                if (numeral(c))
                    keep_char(c);
                else if (c != ntl_pkg::CH_UNDER)
                begin
                    close_tok(ntl_pkg::KIND_UINT);
                    start_fresh(c);
                end
            ntl_pkg::MODE_BASE:
                if (lc == "b" || lc == "d" || lc == "o" || lc == "h")
                begin
                    keep_char(lc);
                    mode = ntl_pkg::MODE_DIGITS;
                end
                else
                    close_tok(ntl_pkg::KIND_ERR);
            ntl_pkg::MODE_DIGITS:
                if (numeral(lc) || (lc >= "a" && lc <= "f"))
                    keep_char(lc);
                else if (c != ntl_pkg::CH_UNDER)
                begin
                    close_tok(ntl_pkg::KIND_BASED);
                    start_fresh(c);
                end
            default:
                start_fresh(c);
        endcase
        if (c == ntl_pkg::CH_LF)
        begin
            if (line_no != '1)
                line_no++;
            col_no = '0;
        end
    endfunction

    function automatic void put(ntl_pkg::char_t c);
        src_words.push_back('{c, 1'b0, pause_len(src_quiet), drain_next});
        drain_next = 1'b0;
        words_built++;
        if ($urandom_range(0, 59) == 0)
            src_quiet = !src_quiet;
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endfunction

    function automatic ntl_pkg::char_t word_char();
        int r;
        r = $urandom_range(0, 63);
        if (r < 26)
            return ntl_pkg::char_t'("a" + r);
        else if (r < 52)
            return ntl_pkg::char_t'("A" + r - 26);
        else if (r < 62)
            return ntl_pkg::char_t'("0" + r - 52);
        return ntl_pkg::CH_UNDER;
    endfunction

    function automatic ntl_pkg::char_t pick_of(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic ntl_pkg::char_t any_char();
        return ntl_pkg::char_t'($urandom_range(0, 255));
    endfunction

    function automatic void add_token();
        string s;
        ntl_pkg::char_t c;
        int n;
        case ($urandom_range(0, 13))
            0, 1:
            begin
                do c = word_char(); while (numeral(c));
                put(c);
                repeat ($urandom_range(0, 10))
                    put(word_char());
            end
            2:
            begin
                s = kw_word[$urandom_range(0, ntl_pkg::NUM_KW - 1)];
                case ($urandom_range(0, 3))
                    0: put_str(s);
                    1: put_str(s.substr(0, $urandom_range(0, s.len() - 2)));
                    2:
                    begin
                        put_str(s);
                        put(word_char());
                    end
                    default:
                    begin
                        put(ntl_pkg::char_t'(s[0] - 8'd32));
                        put_str(s.substr(1, s.len() - 1));
                    end
                endcase
            end
            3:
            begin
                put(ntl_pkg::CH_BSLASH);
                repeat ($urandom_range(0, 6))
                begin
                    do c = any_char(); while (blank(c));
                    put(c);
                end
                put(pick_of(" \t\n"));
            end
            4:
            begin
                put(pick_of("0123456789"));
                repeat ($urandom_range(0, 5))
                    put(pick_of("0123456789_"));
            end
            5, 13:
            begin
                if ($urandom_range(0, 1))
                    put(pick_of("123456789"));
                put(ntl_pkg::CH_QUOTE);
                put(pick_of("bBdDoOhH"));
                repeat ($urandom_range(0, 6))
                    put(pick_of("0123456789abcdefABCDEF_"));
                if ($urandom_range(0, 3) == 0)
                    put(pick_of("gxzZ"));
            end
            6, 7:
                put(pick_of(punct_chars));
            8:
            begin
                put_str("//");
                repeat ($urandom_range(0, 10))
                begin
                    do c = any_char(); while (c == ntl_pkg::CH_LF);
                    put(c);
                end
                put(ntl_pkg::CH_LF);
            end
            9:
            begin
                put_str("/*");
                repeat ($urandom_range(0, 8))
                    put(pick_of("a *\n/x*"));
                put_str("*/");
            end
            10:
                repeat ($urandom_range(1, 3))
                    put(pick_of(" \t\n\r\013\014"));
            11:
                put(any_char());
            default:
            begin
                if ($urandom_range(0, 1))
                begin
                    put(ntl_pkg::CH_SLASH);
                    do c = any_char();
                    while (c == ntl_pkg::CH_SLASH || c == ntl_pkg::CH_STAR);
                    put(c);
                end
                else
                begin
                    put(ntl_pkg::CH_QUOTE);
                    do c = any_char(); while (fold_case(c) inside {"b", "d", "o", "h"});
                    put(c);
                end
            end
        endcase
        n = $urandom_range(0, 9);
        if (n < 4)
            put(" ");
        else if (n < 6)
            put(ntl_pkg::CH_LF);
        else if (n == 6)
            put(pick_of(punct_chars));
    endfunction

    task automatic build_stimulus();
        int start;
        for (int k = 0; k < ntl_pkg::NUM_KW; k++)
        begin
            put_str(kw_word[k]);
            put(punct_chars[k]);
        end
        for (int p = 0; p < punct_chars.len(); p++)
            put(punct_chars[p]);
        put(8'h00);
        put(8'hFF);
        put_str("/q '% 8'HfA_9g 1_0\n\\e\\sc\t/* a ** b */// c\n");
        drain_next = 1'b1;

        start = words_built;
        while (words_built < start + RANDOM_WORDS)
        begin
            if ($urandom_range(0, 40) == 0)
                drain_next = 1'b1;
            add_token();
        end
        put(ntl_pkg::CH_LF);
        put_str("/* z */ wire=q\n");

        case ($urandom_range(0, 9))
            0: end_note = "between tokens";
            1: begin put_str("abc"); end_note = "inside an identifier"; end
            2: begin put_str("wire"); end_note = "inside a keyword"; end
            3: begin put_str("\\q"); end_note = "inside an escaped identifier"; end
            4: begin put_str("12"); end_note = "inside an unsigned number"; end
            5: begin put_str("4'h"); end_note = "inside a based number"; end
            6: begin put(ntl_pkg::CH_QUOTE); end_note = "after a bare quote"; end
            7: begin put(ntl_pkg::CH_SLASH); end_note = "after a bare slash"; end
            8: begin put_str("/* x *"); end_note = "inside a block comment"; end
            default: begin put_str("// x"); end_note = "inside a line comment"; end
        endcase
        drain_next = 1'($urandom_range(0, 1));
        src_words.push_back('{any_char(), 1'b1, pause_len(1'b0), drain_next});
        post_end_words = $urandom_range(1, 4);
        repeat (post_end_words)
            src_words.push_back('{any_char(), 1'($urandom_range(0, 1)),
                                  pause_len(1'b0), 1'b0});
    endtask

    function automatic string show(ntl_pkg::rec_t r);
        return $sformatf("text=%h end=%b kind=%0d col=%0d line=%0d len=%0d", r.text_byte,
                         r.token_end, r.kind, r.start_column, r.line_number, r.text_length);
    endfunction

    function automatic void note_fail(string msg);
        fails++;
        if (fails <= SHOW_MAX)
            $display("MISMATCH: %s", msg);
    endfunction

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_if.valid        <= 1'b0;
            chars_if.in_byte      <= '0;
            chars_if.end_of_input <= 1'b0;
            wait_cnt = 0;
            mode = ntl_pkg::MODE_IDLE;
            line_no = ntl_pkg::line_out_t'(1);
            col_no = '0;
            tok_col = '0;
            tok_len = 0;
            cand = ntl_pkg::KW_ALL;
            eof_seen = 1'b0;
        end
        else
        begin
            if (chars_if.valid && chars_if.ready)
            begin
                lex_char(chars_if.in_byte, chars_if.end_of_input);
                words_sent++;
            end
            if (!chars_if.valid || chars_if.ready)
            begin
                if (src_words.size() > 0 && wait_cnt >= src_words[0].gap &&
                    !(src_words[0].drain && pending_recs.size() > 0))
                begin
                    nxt = src_words.pop_front();
                    chars_if.in_byte      <= nxt.ch;
                    chars_if.end_of_input <= nxt.eoi;
                    chars_if.valid        <= 1'b1;
                    wait_cnt = 0;
                end
                else
                begin
                    chars_if.valid <= 1'b0;
                    if (src_words.size() > 0)
                        wait_cnt++;
                end
            end
        end
    end

    // record side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tokens_if.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (tokens_if.valid && tokens_if.ready)
            begin
                got.text_byte    = tokens_if.text_byte;
                got.token_end    = tokens_if.token_end;
                got.kind         = tokens_if.kind;
                got.start_column = tokens_if.start_column;
                got.line_number  = tokens_if.line_number;
                got.text_length  = tokens_if.text_length;
                recs_seen++;
                if (pending_recs.size() == 0)
                    note_fail($sformatf("record %0d not expected: %s", recs_seen, show(got)));
                else
                begin
                    want = pending_recs.pop_front();
                    diffs = "";
                    if (got.text_byte !== want.text_byte)
                        diffs = {diffs, " text_byte"};
                    if (got.token_end !== want.token_end)
                        diffs = {diffs, " token_end"};
                    if (got.kind !== want.kind)
                        diffs = {diffs, " kind"};
                    if (got.start_column !== want.start_column)
                        diffs = {diffs, " start_column"};
                    if (got.line_number !== want.line_number)
                        diffs = {diffs, " line_number"};
                    if (got.text_length !== want.text_length)
                        diffs = {diffs, " text_length"};
                    if (diffs != "")
                        note_fail($sformatf("record %0d,%s: expected %s, got %s", recs_seen,
                                            diffs, show(want), show(got)));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                tokens_if.ready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 99) == 0)
                    sink_quiet = !sink_quiet;
                stall_left = pause_len(sink_quiet);
                tokens_if.ready <= (stall_left == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d records outstanding", cycles,
                     pending_recs.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        chars_if.valid        = 1'b0;
        chars_if.in_byte      = '0;
        chars_if.end_of_input = 1'b0;
        tokens_if.ready       = 1'b0;
        build_stimulus();
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        while (src_words.size() > 0 || chars_if.valid)
            @(posedge clk);
        while (pending_recs.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_recs.size() != 0)
            note_fail($sformatf("%0d records never arrived", pending_recs.size()));
        $display("lexed %0d source words (%0d after end of input), checked %0d token records",
                 words_sent, post_end_words, recs_seen);
        $display("input ended %s; keywords, comments, numbers and stray bytes mixed, %0d errors",
                 end_note, fails);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
